### rtl/ict_pkg.sv
`default_nettype none

package ict_pkg;

  // Configuration port geometry
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_OFFSET    = 3'd0;
  localparam logic [2:0] REG_L1_INDEX  = 3'd1;
  localparam logic [2:0] REG_L2_INDEX  = 3'd2;
  localparam logic [2:0] REG_L1_WAYS   = 3'd3;
  localparam logic [2:0] REG_L2_WAYS   = 3'd4;

  // Tags are compared in a 62-bit tag space
  localparam int TAG_SPACE_W = 62;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [3:0] offset;
    logic [2:0] l1_ib;
    logic [3:0] l2_ib;
    logic [2:0] l1_ways;
    logic [3:0] l2_ways;
  } cfg_t;

  // Flags of one result item
  typedef struct packed {
    logic l1_hit;
    logic l2_hit;
    logic wb1;
    logic binv;
    logic binvd;
    logic wb2;
  } res_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_RD1,
    S_L1,
    S_E1,
    S_RD2,
    S_L2,
    S_BI,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

### rtl/inclusive_two_level_cache_tags.sv
// Tag and state controller for an inclusive two-level cache pair.
// Input channel (in_valid / in_stall): one access, read or write, with its
// byte address. Result channel (out_valid / out_stall): one item per access
// with the L1 hit, L2 hit, writeback and back-invalidate flags.
// Configuration goes through the APB port (block size, sets and ways in use).
// The user must write it only while no access is in flight; the block itself
// does not enforce this. Each set of each level is one row of a
// single-port-write, registered-read memory; every access reads, modifies and
// writes back rows, one memory read per cycle per level. An L1 hit finishes
// after the L1 lookup. An L1 miss goes on to L2; its path depends on whether a
// dirty L1 victim must update L2 and whether the L2 victim needs a
// back-invalidate lookup in L1. The result then passes from the pending slot
// into the output register. A new access is not taken while the previous one
// is still being processed.
// A new item is taken once the previous result has left the pending slot, so
// a result waiting under out_stall does not block the next access.
// After reset both memories are swept clean, one row a cycle, over
// max(L1_SETS, L2_SETS) rows (512 by default); in_stall stays high meanwhile.
// A stalled result holds on the output ports until taken.
`default_nettype none

module inclusive_two_level_cache_tags #(
  parameter int L1_SETS   = 64,
  parameter int L1_WAYS   = 4,
  parameter int L2_SETS   = 512,
  parameter int L2_WAYS   = 8,
  parameter int ADDR_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [ADDR_BITS-1:0]          in_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_l1_hit,
  output logic                          out_l2_hit,
  output logic                          out_l1_victim_writeback,
  output logic                          out_back_invalidate,
  output logic                          out_back_invalidate_dirty,
  output logic                          out_l2_victim_writeback,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ict_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [ict_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [ict_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  localparam int TSW   = ict_pkg::TAG_SPACE_W;
  localparam int L1_AW = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
  localparam int L2_AW = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
  localparam int L1_IW = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
  localparam int L2_IW = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int L1_CW = $clog2(L1_WAYS + 1);
  localparam int L2_CW = $clog2(L2_WAYS + 1);
  localparam int L1_RW = L1_WAYS * (2 + L1_IW + ADDR_BITS);
  localparam int L2_RW = L2_WAYS * (2 + L2_IW + ADDR_BITS);
  localparam int CLR_ROWS = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
  localparam int CLR_W = (CLR_ROWS > 1) ? $clog2(CLR_ROWS) : 1;

  ict_pkg::cfg_t cfg;

  // Control and payload registers
  ict_pkg::state_t state_r, state_nxt;
  logic                 func_r, func_nxt;
  logic [L1_AW-1:0]     set1_r, set1_nxt;
  logic [ADDR_BITS-1:0] tag1_r, tag1_nxt;
  logic [L2_AW-1:0]     set2_r, set2_nxt;
  logic [ADDR_BITS-1:0] tag2_r, tag2_nxt;
  logic [L1_IW-1:0]     v1_r, v1_nxt;
  logic [L2_AW-1:0]     es2_r, es2_nxt;
  logic [TSW-1:0]       et2_r, et2_nxt;
  logic [L1_AW-1:0]     es1_r, es1_nxt;
  logic [TSW-1:0]       et1_r, et1_nxt;
  logic                 dv2_r, dv2_nxt;
  logic [L1_WAYS-1:0]                   f_valid_r, f_valid_nxt;
  logic [L1_WAYS-1:0]                   f_dirty_r, f_dirty_nxt;
  logic [L1_WAYS-1:0][L1_IW-1:0]        f_ages_r, f_ages_nxt;
  logic [L1_WAYS-1:0][ADDR_BITS-1:0]    f_tags_r, f_tags_nxt;
  logic [L2_RW-1:0]     l2row_r, l2row_nxt;
  ict_pkg::res_t        res_r, res_nxt;
  logic                 pend_r, pend_nxt;
  ict_pkg::res_t        out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CLR_W-1:0]     cnt_r, cnt_nxt;

  // Memory ports
  logic                 l1_we, l2_we;
  logic [L1_AW-1:0]     l1_waddr, l1_raddr;
  logic [L2_AW-1:0]     l2_waddr, l2_raddr;
  logic [L1_RW-1:0]     l1_wdata, l1_rdata;
  logic [L2_RW-1:0]     l2_wdata, l2_rdata;

  // Row views of the read data
  logic [L1_WAYS-1:0]                   r1_valid, r1_dirty;
  logic [L1_WAYS-1:0][L1_IW-1:0]        r1_ages;
  logic [L1_WAYS-1:0][ADDR_BITS-1:0]    r1_tags;
  logic [L2_WAYS-1:0]                   r2_valid, r2_dirty;
  logic [L2_WAYS-1:0][L2_IW-1:0]        r2_ages;
  logic [L2_WAYS-1:0][ADDR_BITS-1:0]    r2_tags;

  // Set unit results
  logic                          u1_hit, u2_hit;
  logic [L1_IW-1:0]              u1_hit_way, u1_vict;
  logic [L2_IW-1:0]              u2_hit_way, u2_vict;
  logic [L1_WAYS-1:0][L1_IW-1:0] u1_ages_t;
  logic [L2_WAYS-1:0][L2_IW-1:0] u2_ages_t;
  logic [TSW-1:0]                u1_tag, u2_tag;

  logic [63:0]          mask1, mask2;
  logic                 in_acc;

  assign {r1_tags, r1_ages, r1_dirty, r1_valid} = l1_rdata;
  assign {r2_tags, r2_ages, r2_dirty, r2_valid} = l2_rdata;

  assign mask1 = (64'd1 << cfg.l1_ib) - 64'd1;
  assign mask2 = (64'd1 << cfg.l2_ib) - 64'd1;

  assign in_stall = (state_r != ict_pkg::S_IDLE) || pend_r;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid                 = out_valid_r;
  assign out_l1_hit                = out_r.l1_hit;
  assign out_l2_hit                = out_r.l2_hit;
  assign out_l1_victim_writeback   = out_r.wb1;
  assign out_back_invalidate       = out_r.binv;
  assign out_back_invalidate_dirty = out_r.binvd;
  assign out_l2_victim_writeback   = out_r.wb2;

  assign u1_tag = (state_r == ict_pkg::S_BI) ? et1_r : TSW'(tag1_r);
  assign u2_tag = (state_r == ict_pkg::S_E1) ? et2_r : TSW'(tag2_r);

  ict_cfg #(
    .L1_SETS (L1_SETS),
    .L1_WAYS (L1_WAYS),
    .L2_SETS (L2_SETS),
    .L2_WAYS (L2_WAYS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ict_ram #(.WIDTH(L1_RW), .DEPTH(L1_SETS)) u_l1_ram (
    .clk   (clk),
    .we    (l1_we),
    .waddr (l1_waddr),
    .wdata (l1_wdata),
    .raddr (l1_raddr),
    .rdata (l1_rdata)
  );

  ict_ram #(.WIDTH(L2_RW), .DEPTH(L2_SETS)) u_l2_ram (
    .clk   (clk),
    .we    (l2_we),
    .waddr (l2_waddr),
    .wdata (l2_wdata),
    .raddr (l2_raddr),
    .rdata (l2_rdata)
  );

  ict_set_unit #(.WAYS(L1_WAYS), .TAG_W(ADDR_BITS)) u_l1_set (
    .ways         (L1_CW'(cfg.l1_ways)),
    .valid        (r1_valid),
    .ages         (r1_ages),
    .tags         (r1_tags),
    .lookup       (u1_tag),
    .hit          (u1_hit),
    .hit_way      (u1_hit_way),
    .vict_way     (u1_vict),
    .ages_touched (u1_ages_t)
  );

  ict_set_unit #(.WAYS(L2_WAYS), .TAG_W(ADDR_BITS)) u_l2_set (
    .ways         (L2_CW'(cfg.l2_ways)),
    .valid        (r2_valid),
    .ages         (r2_ages),
    .tags         (r2_tags),
    .lookup       (u2_tag),
    .hit          (u2_hit),
    .hit_way      (u2_hit_way),
    .vict_way     (u2_vict),
    .ages_touched (u2_ages_t)
  );

  // State and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ict_pkg::S_CLR;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    set1_r    <= set1_nxt;
    tag1_r    <= tag1_nxt;
    set2_r    <= set2_nxt;
    tag2_r    <= tag2_nxt;
    v1_r      <= v1_nxt;
    es2_r     <= es2_nxt;
    et2_r     <= et2_nxt;
    es1_r     <= es1_nxt;
    et1_r     <= et1_nxt;
    dv2_r     <= dv2_nxt;
    f_valid_r <= f_valid_nxt;
    f_dirty_r <= f_dirty_nxt;
    f_ages_r  <= f_ages_nxt;
    f_tags_r  <= f_tags_nxt;
    l2row_r   <= l2row_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  // Sequencer: read, modify and write back the sets of one access
  always_comb begin
    logic [ADDR_BITS-1:0]              blk;
    logic [63:0]                       vblk;
    logic [L1_WAYS-1:0]                m1_valid, m1_dirty;
    logic [L2_WAYS-1:0]                m2_valid, m2_dirty;
    logic [L2_WAYS-1:0][ADDR_BITS-1:0] m2_tags;

    blk  = '0;
    vblk = '0;
    m1_valid = r1_valid;
    m1_dirty = r1_dirty;
    m2_valid = r2_valid;
    m2_dirty = r2_dirty;
    m2_tags  = r2_tags;

    state_nxt     = state_r;
    func_nxt      = func_r;
    set1_nxt      = set1_r;
    tag1_nxt      = tag1_r;
    set2_nxt      = set2_r;
    tag2_nxt      = tag2_r;
    v1_nxt        = v1_r;
    es2_nxt       = es2_r;
    et2_nxt       = et2_r;
    es1_nxt       = es1_r;
    et1_nxt       = et1_r;
    dv2_nxt       = dv2_r;
    f_valid_nxt   = f_valid_r;
    f_dirty_nxt   = f_dirty_r;
    f_ages_nxt    = f_ages_r;
    f_tags_nxt    = f_tags_r;
    l2row_nxt     = l2row_r;
    res_nxt       = res_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;

    l1_we    = 1'b0;
    l1_waddr = set1_r;
    l1_wdata = l1_rdata;
    l1_raddr = set1_r;
    l2_we    = 1'b0;
    l2_waddr = set2_r;
    l2_wdata = l2_rdata;
    l2_raddr = set2_r;

    // Move a finished item into the output register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pend_r && (!out_valid_r || !out_stall)) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
      pend_nxt      = 1'b0;
    end

    unique case (state_r)
      ict_pkg::S_CLR: begin
        l1_we    = {1'b0, cnt_r} < (CLR_W + 1)'(L1_SETS);
        l1_waddr = L1_AW'(cnt_r);
        l1_wdata = '0;
        l2_we    = {1'b0, cnt_r} < (CLR_W + 1)'(L2_SETS);
        l2_waddr = L2_AW'(cnt_r);
        l2_wdata = '0;
        if (cnt_r == CLR_W'(CLR_ROWS - 1)) begin
          state_nxt = ict_pkg::S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ict_pkg::S_IDLE: begin
        if (in_acc) begin
          blk       = in_address >> cfg.offset;
          func_nxt  = in_func;
          set1_nxt  = L1_AW'(64'(blk) & mask1);
          tag1_nxt  = blk >> cfg.l1_ib;
          set2_nxt  = L2_AW'(64'(blk) & mask2);
          tag2_nxt  = blk >> cfg.l2_ib;
          res_nxt   = '0;
          state_nxt = ict_pkg::S_RD1;
        end
      end

      ict_pkg::S_RD1: begin
        l1_raddr  = set1_r;
        state_nxt = ict_pkg::S_L1;
      end

      ict_pkg::S_L1: begin
        if (u1_hit) begin
          // Hit: age the set, mark dirty on a write
          if (func_r) begin
            m1_dirty[u1_hit_way] = 1'b1;
          end
          l1_we          = 1'b1;
          l1_waddr       = set1_r;
          l1_wdata       = {r1_tags, u1_ages_t, m1_dirty, r1_valid};
          res_nxt.l1_hit = 1'b1;
          pend_nxt       = 1'b1;
          state_nxt      = ict_pkg::S_IDLE;
        end else begin
          // Miss: build the filled L1 row now, write it at the end
          f_valid_nxt          = r1_valid;
          f_valid_nxt[u1_vict] = 1'b1;
          f_dirty_nxt          = r1_dirty;
          f_dirty_nxt[u1_vict] = func_r;
          f_ages_nxt           = u1_ages_t;
          f_tags_nxt           = r1_tags;
          f_tags_nxt[u1_vict]  = tag1_r;
          v1_nxt               = u1_vict;
          if (r1_valid[u1_vict] && r1_dirty[u1_vict]) begin
            res_nxt.wb1 = 1'b1;
            vblk        = (64'(r1_tags[u1_vict]) << cfg.l1_ib) | 64'(set1_r);
            es2_nxt     = L2_AW'(vblk & mask2);
            et2_nxt     = TSW'(vblk >> cfg.l2_ib);
            l2_raddr    = es2_nxt;
            state_nxt   = ict_pkg::S_E1;
          end else begin
            l2_raddr  = set2_r;
            state_nxt = ict_pkg::S_L2;
          end
        end
      end

      ict_pkg::S_E1: begin
        // Mark the L2 copy of the dirty L1 victim
        if (u2_hit) begin
          m2_dirty[u2_hit_way] = 1'b1;
          l2_we    = 1'b1;
          l2_waddr = es2_r;
          l2_wdata = {r2_tags, u2_ages_t, m2_dirty, r2_valid};
        end
        state_nxt = ict_pkg::S_RD2;
      end

      ict_pkg::S_RD2: begin
        l2_raddr  = set2_r;
        state_nxt = ict_pkg::S_L2;
      end

      ict_pkg::S_L2: begin
        if (u2_hit) begin
          res_nxt.l2_hit = 1'b1;
          l2row_nxt      = {r2_tags, u2_ages_t, r2_dirty, r2_valid};
          state_nxt      = ict_pkg::S_FIN;
        end else begin
          m2_valid[u2_vict] = 1'b1;
          m2_dirty[u2_vict] = 1'b0;
          m2_tags[u2_vict]  = tag2_r;
          l2row_nxt         = {m2_tags, u2_ages_t, m2_dirty, m2_valid};
          if (r2_valid[u2_vict]) begin
            // Look for an L1 copy of the L2 victim
            dv2_nxt   = r2_dirty[u2_vict];
            vblk      = (64'(r2_tags[u2_vict]) << cfg.l2_ib) | 64'(set2_r);
            es1_nxt   = L1_AW'(vblk & mask1);
            et1_nxt   = TSW'(vblk >> cfg.l1_ib);
            l1_raddr  = es1_nxt;
            state_nxt = ict_pkg::S_BI;
          end else begin
            state_nxt = ict_pkg::S_FIN;
          end
        end
      end

      ict_pkg::S_BI: begin
        res_nxt.wb2 = dv2_r;
        if (u1_hit) begin
          // Drop the L1 copy, pass its dirtiness on
          m1_valid[u1_hit_way] = 1'b0;
          l1_we        = 1'b1;
          l1_waddr     = es1_r;
          l1_wdata     = {r1_tags, r1_ages, r1_dirty, m1_valid};
          res_nxt.binv = 1'b1;
          if (r1_dirty[u1_hit_way]) begin
            res_nxt.binvd = 1'b1;
            res_nxt.wb2   = 1'b1;
          end
          if (es1_r == set1_r && u1_hit_way != v1_r) begin
            f_valid_nxt[u1_hit_way] = 1'b0;
          end
        end
        state_nxt = ict_pkg::S_FIN;
      end

      ict_pkg::S_FIN: begin
        l1_we     = 1'b1;
        l1_waddr  = set1_r;
        l1_wdata  = {f_tags_r, f_ages_r, f_dirty_r, f_valid_r};
        l2_we     = 1'b1;
        l2_waddr  = set2_r;
        l2_wdata  = l2row_r;
        pend_nxt  = 1'b1;
        state_nxt = ict_pkg::S_IDLE;
      end

      default: begin
        state_nxt = ict_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ict_pkg::S_RD1)
    else $error("accepted item did not start an L1 read");

  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ict_pkg::S_FIN |-> !pend_r)
    else $error("result finished while previous one still pending");

  a_out_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pend_r))
    else $error("output became valid without a pending result");

  a_l1_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.l1_hit |-> !out_r.l2_hit && !out_r.wb1 && !out_r.binv
      && !out_r.binvd && !out_r.wb2)
    else $error("L1 hit item carries miss flags");

  a_binvd_implies: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.binvd |-> out_r.binv && out_r.wb2 && !out_r.l2_hit)
    else $error("dirty back-invalidate without invalidate and writeback");
`endif

endmodule

`default_nettype wire

### rtl/ict_ram.sv
`default_nettype none

module ict_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one row, read one row with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/ict_cfg.sv
`default_nettype none

module ict_cfg #(
  parameter int L1_SETS = 64,
  parameter int L1_WAYS = 4,
  parameter int L2_SETS = 512,
  parameter int L2_WAYS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ict_pkg::CFG_AW-1:0]    paddr,
  input  logic [ict_pkg::CFG_DW-1:0]    pwdata,
  output logic [ict_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output ict_pkg::cfg_t                 cfg
);

  localparam int L1_IB_MAX = $clog2(L1_SETS + 1) - 1;
  localparam int L2_IB_MAX = $clog2(L2_SETS + 1) - 1;

  logic [3:0] offset_r;
  logic [2:0] l1_ib_r;
  logic [3:0] l2_ib_r;
  logic [2:0] l1_ways_r;
  logic [3:0] l2_ways_r;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= 4'd6;
      l1_ib_r   <= 3'd6;
      l2_ib_r   <= 4'd9;
      l1_ways_r <= 3'd4;
      l2_ways_r <= 4'd8;
    end else if (wr) begin
      unique case (idx)
        ict_pkg::REG_OFFSET:   offset_r  <= pwdata[3:0];
        ict_pkg::REG_L1_INDEX: l1_ib_r   <= pwdata[2:0];
        ict_pkg::REG_L2_INDEX: l2_ib_r   <= pwdata[3:0];
        ict_pkg::REG_L1_WAYS:  l1_ways_r <= pwdata[2:0];
        ict_pkg::REG_L2_WAYS:  l2_ways_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back the raw values
  always_comb begin
    prdata = '0;
    unique case (idx)
      ict_pkg::REG_OFFSET:   prdata = ict_pkg::CFG_DW'(offset_r);
      ict_pkg::REG_L1_INDEX: prdata = ict_pkg::CFG_DW'(l1_ib_r);
      ict_pkg::REG_L2_INDEX: prdata = ict_pkg::CFG_DW'(l2_ib_r);
      ict_pkg::REG_L1_WAYS:  prdata = ict_pkg::CFG_DW'(l1_ways_r);
      ict_pkg::REG_L2_WAYS:  prdata = ict_pkg::CFG_DW'(l2_ways_r);
      default:               prdata = '0;
    endcase
  end

  // Clamp to what the arrays hold; zero ways acts as one
  always_comb begin
    cfg.offset  = offset_r;
    cfg.l1_ib   = (int'(l1_ib_r) > L1_IB_MAX) ? 3'(L1_IB_MAX) : l1_ib_r;
    cfg.l2_ib   = (int'(l2_ib_r) > L2_IB_MAX) ? 4'(L2_IB_MAX) : l2_ib_r;
    cfg.l1_ways = (l1_ways_r == 3'd0) ? 3'd1 :
                  (int'(l1_ways_r) > L1_WAYS) ? 3'(L1_WAYS) : l1_ways_r;
    cfg.l2_ways = (l2_ways_r == 4'd0) ? 4'd1 :
                  (int'(l2_ways_r) > L2_WAYS) ? 4'(L2_WAYS) : l2_ways_r;
  end

endmodule

`default_nettype wire

### rtl/ict_set_unit.sv
`default_nettype none

module ict_set_unit #(
  parameter int WAYS  = 4,
  parameter int TAG_W = 48,
  localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int CW = $clog2(WAYS + 1)
) (
  input  logic [CW-1:0]                     ways,
  input  logic [WAYS-1:0]                   valid,
  input  logic [WAYS-1:0][IW-1:0]           ages,
  input  logic [WAYS-1:0][TAG_W-1:0]        tags,
  input  logic [ict_pkg::TAG_SPACE_W-1:0]   lookup,
  output logic                              hit,
  output logic [IW-1:0]                     hit_way,
  output logic [IW-1:0]                     vict_way,
  output logic [WAYS-1:0][IW-1:0]           ages_touched
);

  logic          found_inv;
  logic [IW-1:0] best;
  logic [IW-1:0] sel;
  logic [IW-1:0] sel_age;

  // Find the first valid way that matches
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (j < int'(ways) && valid[j] &&
          ict_pkg::TAG_SPACE_W'(tags[j]) == lookup) begin
        hit     = 1'b1;
        hit_way = IW'(j);
      end
    end
  end

  // Pick the first invalid way, else the oldest
  always_comb begin
    found_inv = 1'b0;
    best      = '0;
    vict_way  = '0;
    for (int j = 0; j < WAYS; j++) begin
      if (j < int'(ways) && !found_inv) begin
        if (!valid[j]) begin
          found_inv = 1'b1;
          vict_way  = IW'(j);
        end else if (ages[j] > ages[best]) begin
          best = IW'(j);
        end
      end
    end
    if (!found_inv) begin
      vict_way = best;
    end
  end

  // Age the set around the touched way
  assign sel     = hit ? hit_way : vict_way;
  assign sel_age = ages[sel];

  always_comb begin
    ages_touched = ages;
    for (int j = 0; j < WAYS; j++) begin
      if (j < int'(ways) && IW'(j) != sel && ages[j] <= sel_age &&
          int'(ages[j]) < int'(ways) - 1) begin
        ages_touched[j] = IW'(ages[j] + 1'b1);
      end
    end
    ages_touched[sel] = '0;
  end

endmodule

`default_nettype wire
